### rtl/desu_pkg.sv
// Package for the damaged elastic stress update block.
// Widths, configuration register indexes and shared types; no dependencies.
package desu_pkg;

    localparam int NCOMP    = 6;
    localparam int NNORM    = 3;
    localparam int NOPS     = NCOMP + NNORM;
    localparam int STRAIN_W = 32;
    localparam int STRESS_W = 48;
    localparam int COEF_W   = 64;
    localparam int HALF_W   = 32;
    localparam int PROD1_W  = 56;
    localparam int EPS_W    = 40;
    localparam int EK_W     = 58;
    localparam int OP_W     = 59;
    localparam int OPH_W    = OP_W - HALF_W;
    localparam int PPS_W    = HALF_W + 1 + OPH_W;
    localparam int PROD_W   = 123;
    localparam int ACC_W    = 124;
    localparam int RSHIFT   = 62;
    localparam int NUM_W    = 81;
    localparam int DEN_W    = 33;
    localparam int REM_W    = 35;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [2:0] CFG_DIMENSION      = 3'd0;
    localparam logic [2:0] CFG_PLANE_STRAIN   = 3'd1;
    localparam logic [2:0] CFG_YOUNGS_MODULUS = 3'd2;
    localparam logic [2:0] CFG_POISSON_RATIO  = 3'd3;
    localparam logic [2:0] CFG_THERMAL_EXP    = 3'd4;
    localparam logic [2:0] CFG_THERMAL_ENABLE = 3'd5;

    localparam logic [1:0] DIM_NONE = 2'd0;
    localparam logic [1:0] DIM_1D   = 2'd1;
    localparam logic [1:0] DIM_2D   = 2'd2;
    localparam logic [1:0] DIM_3D   = 2'd3;

    typedef logic [COEF_W-1:0] t_coef;

endpackage

### rtl/damaged_elastic_stress_update.sv
// Damaged isotropic linear elastic stress update, top level.
// Depends on desu_pkg.
//
// Usage: write the configuration registers through the cfg channel (index,
// data, valid; ready is always high). Each write, and reset, starts a
// coefficient pass that derives the stiffness entries with a shared
// bit-serial divider: three divisions of 81 steps, each after a setup
// state, while busy is high. With busy low, an integration point is taken
// at every edge where start is high: one word per cycle. The pipeline has
// eight register stages; the result word shows on the o_stress ports with
// o_strobe high for one cycle, once the point has passed through them all.
// The receiver cannot stall, so no back-pressure exists and the pipeline
// never holds. Reset restores the register defaults, empties the pipeline
// and runs the coefficient pass.
module damaged_elastic_stress_update (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [16:0]          i_damage,
    input  logic signed [23:0]   i_delta_temp,
    input  logic signed [31:0]   i_strain_0,
    input  logic signed [31:0]   i_strain_1,
    input  logic signed [31:0]   i_strain_2,
    input  logic signed [31:0]   i_strain_3,
    input  logic signed [31:0]   i_strain_4,
    input  logic signed [31:0]   i_strain_5,
    output logic                 o_strobe,
    output logic signed [47:0]   o_stress_0,
    output logic signed [47:0]   o_stress_1,
    output logic signed [47:0]   o_stress_2,
    output logic signed [47:0]   o_stress_3,
    output logic signed [47:0]   o_stress_4,
    output logic signed [47:0]   o_stress_5,
    output logic                 o_saturated
);

    localparam logic [1:0] CS_IDLE = 2'd0;
    localparam logic [1:0] CS_PREP = 2'd1;
    localparam logic [1:0] CS_DIV  = 2'd2;

    localparam logic [1:0] C_SH = 2'd0;
    localparam logic [1:0] C_DG = 2'd1;
    localparam logic [1:0] C_CP = 2'd2;

    localparam int NC  = desu_pkg::NCOMP;
    localparam int NN  = desu_pkg::NNORM;
    localparam int NO  = desu_pkg::NOPS;
    localparam int HW  = desu_pkg::HALF_W;

    // configuration registers
    logic [1:0]         r_dimension;
    logic               r_plane_strain;
    logic [31:0]        r_youngs;
    logic [14:0]        r_poisson;
    logic signed [31:0] r_alpha;
    logic               r_thermal_en;

    // coefficient sequencer
    logic [1:0]                       r_cstate;
    logic [1:0]                       r_csel;
    logic [6:0]                       r_cnt;
    logic [desu_pkg::NUM_W-1:0]       r_num;
    logic [desu_pkg::REM_W-1:0]       r_rem;
    logic [desu_pkg::DEN_W-1:0]       r_den;
    desu_pkg::t_coef                  r_sh;
    desu_pkg::t_coef                  r_dg;
    desu_pkg::t_coef                  r_cp;

    logic                             plane_stress;
    logic [16:0]                      n17;
    logic [16:0]                      prep_x;
    logic [48:0]                      prep_num;
    logic [desu_pkg::DEN_W-1:0]       prep_den;
    logic [desu_pkg::REM_W-1:0]       rem_sh;
    logic                             qbit;
    logic [desu_pkg::REM_W-1:0]       rem_nx;
    logic [desu_pkg::NUM_W-1:0]       quot;
    desu_pkg::t_coef                  quot_sat;

    logic accept;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_cstate != CS_IDLE);
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension    <= desu_pkg::DIM_2D;
            r_plane_strain <= 1'b0;
            r_youngs       <= '0;
            r_poisson      <= '0;
            r_alpha        <= '0;
            r_thermal_en   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                desu_pkg::CFG_DIMENSION:      r_dimension    <= i_cfg_data[1:0];
                desu_pkg::CFG_PLANE_STRAIN:   r_plane_strain <= i_cfg_data[0];
                desu_pkg::CFG_YOUNGS_MODULUS: r_youngs       <= i_cfg_data;
                desu_pkg::CFG_POISSON_RATIO:  r_poisson      <= i_cfg_data[14:0];
                desu_pkg::CFG_THERMAL_EXP:    r_alpha        <= $signed(i_cfg_data);
                desu_pkg::CFG_THERMAL_ENABLE: r_thermal_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        plane_stress = (r_dimension == desu_pkg::DIM_2D) && !r_plane_strain;
        n17          = {2'b00, r_poisson};
        unique case (r_csel)
            C_SH:    prep_x = 17'd1;
            C_DG:    prep_x = plane_stress ? desu_pkg::ONE_Q16 : desu_pkg::ONE_Q16 - n17;
            C_CP:    prep_x = n17;
            default: prep_x = '0;
        endcase
        prep_num = 49'(r_youngs) * 49'(prep_x);
        if (r_csel == C_SH) begin
            prep_den = desu_pkg::DEN_W'({desu_pkg::ONE_Q16 + n17, 1'b0});
        end else if (plane_stress) begin
            prep_den = 33'h1_0000_0000
                     - desu_pkg::DEN_W'(r_poisson) * desu_pkg::DEN_W'(r_poisson);
        end else begin
            prep_den = desu_pkg::DEN_W'(desu_pkg::ONE_Q16 + n17)
                     * desu_pkg::DEN_W'(desu_pkg::ONE_Q16 - {n17[15:0], 1'b0});
        end
        rem_sh   = {r_rem[desu_pkg::REM_W-2:0], r_num[desu_pkg::NUM_W-1]};
        qbit     = (rem_sh >= desu_pkg::REM_W'(r_den));
        rem_nx   = qbit ? rem_sh - desu_pkg::REM_W'(r_den) : rem_sh;
        quot     = {r_num[desu_pkg::NUM_W-2:0], qbit};
        quot_sat = (|quot[desu_pkg::NUM_W-1:desu_pkg::COEF_W]) ? '1
                 : quot[desu_pkg::COEF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cstate <= CS_PREP;
            r_csel   <= C_SH;
            r_cnt    <= '0;
        end else if (i_cfg_valid) begin
            r_cstate <= CS_PREP;
            r_csel   <= C_SH;
        end else begin
            unique case (r_cstate)
                CS_PREP: begin
                    r_cstate <= CS_DIV;
                    r_cnt    <= 7'(desu_pkg::NUM_W - 1);
                end
                CS_DIV: begin
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd0) begin
                        if (r_csel == C_CP) begin
                            r_cstate <= CS_IDLE;
                        end else begin
                            r_cstate <= CS_PREP;
                            r_csel   <= r_csel + 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cstate == CS_PREP) begin
            r_num <= {prep_num, 32'd0};
            r_den <= prep_den;
            r_rem <= '0;
        end else if (r_cstate == CS_DIV) begin
            r_num <= quot;
            r_rem <= rem_nx;
            if (r_cnt == 7'd0) begin
                unique case (r_csel)
                    C_SH:    r_sh <= quot_sat;
                    C_DG:    r_dg <= quot_sat;
                    default: r_cp <= quot_sat;
                endcase
            end
        end
    end

    // stage 1: damage clamp and thermal product
    logic                                  r_v1;
    logic [16:0]                           r_s1_keep;
    logic signed [desu_pkg::PROD1_W-1:0]   r_s1_prod;
    logic signed [desu_pkg::STRAIN_W-1:0]  r_s1_strain [NC];
    logic signed [desu_pkg::STRAIN_W-1:0]  in_strain [NC];

    assign in_strain[0] = i_strain_0;
    assign in_strain[1] = i_strain_1;
    assign in_strain[2] = i_strain_2;
    assign in_strain[3] = i_strain_3;
    assign in_strain[4] = i_strain_4;
    assign in_strain[5] = i_strain_5;

    always_ff @(posedge i_clk) begin
        r_s1_keep <= (i_damage >= desu_pkg::ONE_Q16) ? 17'd0 : desu_pkg::ONE_Q16 - i_damage;
        r_s1_prod <= desu_pkg::PROD1_W'(i_delta_temp) * desu_pkg::PROD1_W'(r_alpha);
        for (int i = 0; i < NC; i++) begin
            r_s1_strain[i] <= in_strain[i];
        end
    end

    // stage 2: thermal strain
    logic                                r_v2;
    logic [16:0]                         r_s2_keep;
    logic signed [desu_pkg::EPS_W-1:0]   r_s2_eps [NC];
    logic signed [56:0]                  th_wide;
    logic signed [desu_pkg::EPS_W-1:0]   th;
    logic [1:0]                          nnorm;
    logic signed [desu_pkg::EPS_W-1:0]   n_eps [NC];

    always_comb begin
        th_wide = -57'(r_s1_prod) + 57'sd131072;
        th      = desu_pkg::EPS_W'($signed(th_wide[56:18]));
        unique case (r_dimension)
            desu_pkg::DIM_1D: nnorm = 2'd1;
            desu_pkg::DIM_2D: nnorm = 2'd2;
            desu_pkg::DIM_3D: nnorm = 2'd3;
            default:          nnorm = 2'd0;
        endcase
        for (int i = 0; i < NC; i++) begin
            n_eps[i] = desu_pkg::EPS_W'(r_s1_strain[i]);
            if (r_thermal_en && (i < int'(nnorm))) begin
                n_eps[i] = n_eps[i] + th;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_keep <= r_s1_keep;
        for (int i = 0; i < NC; i++) begin
            r_s2_eps[i] <= n_eps[i];
        end
    end

    // stage 3: apply remaining stiffness fraction
    logic                               r_v3;
    logic signed [desu_pkg::EK_W-1:0]   r_s3_ek [NC];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NC; i++) begin
            r_s3_ek[i] <= desu_pkg::EK_W'(r_s2_eps[i])
                        * desu_pkg::EK_W'($signed({1'b0, r_s2_keep}));
        end
    end

    // stage 4: coupling sums, operands 0..5 direct, NC..NC+2 coupled
    logic                               r_v4;
    logic signed [desu_pkg::OP_W-1:0]   r_s4_op [NO];
    logic signed [desu_pkg::OP_W-1:0]   n_op [NO];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            n_op[i] = desu_pkg::OP_W'(r_s3_ek[i]);
        end
        for (int i = 0; i < NN; i++) begin
            n_op[NC+i] = '0;
        end
        if (r_dimension == desu_pkg::DIM_3D) begin
            n_op[NC]   = desu_pkg::OP_W'(r_s3_ek[1]) + desu_pkg::OP_W'(r_s3_ek[2]);
            n_op[NC+1] = desu_pkg::OP_W'(r_s3_ek[0]) + desu_pkg::OP_W'(r_s3_ek[2]);
            n_op[NC+2] = desu_pkg::OP_W'(r_s3_ek[0]) + desu_pkg::OP_W'(r_s3_ek[1]);
        end else if (r_dimension == desu_pkg::DIM_2D) begin
            n_op[NC]   = desu_pkg::OP_W'(r_s3_ek[1]);
            n_op[NC+1] = desu_pkg::OP_W'(r_s3_ek[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NO; i++) begin
            r_s4_op[i] <= n_op[i];
        end
    end

    // stage 5: partial products
    logic                                  r_v5;
    logic [2*HW-1:0]                       r_s5_ll [NO];
    logic [2*HW-1:0]                       r_s5_hl [NO];
    logic signed [desu_pkg::PPS_W-1:0]     r_s5_lh [NO];
    logic signed [desu_pkg::PPS_W-1:0]     r_s5_hh [NO];
    desu_pkg::t_coef                       cf [NO];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            cf[i] = r_sh;
        end
        cf[0] = (r_dimension == desu_pkg::DIM_1D) ? {16'd0, r_youngs, 16'd0} : r_dg;
        cf[1] = r_dg;
        cf[2] = (r_dimension == desu_pkg::DIM_3D) ? r_dg : r_sh;
        for (int i = 0; i < NN; i++) begin
            cf[NC+i] = r_cp;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NO; k++) begin
            r_s5_ll[k] <= cf[k][HW-1:0] * r_s4_op[k][HW-1:0];
            r_s5_hl[k] <= cf[k][2*HW-1:HW] * r_s4_op[k][HW-1:0];
            r_s5_lh[k] <= $signed({1'b0, cf[k][HW-1:0]})
                        * $signed(r_s4_op[k][desu_pkg::OP_W-1:HW]);
            r_s5_hh[k] <= $signed({1'b0, cf[k][2*HW-1:HW]})
                        * $signed(r_s4_op[k][desu_pkg::OP_W-1:HW]);
        end
    end

    // stage 6: full products
    logic                                 r_v6;
    logic signed [desu_pkg::PROD_W-1:0]   r_s6_prod [NO];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NO; k++) begin
            r_s6_prod[k] <= desu_pkg::PROD_W'($signed({1'b0, r_s5_ll[k]}))
                          + (desu_pkg::PROD_W'($signed({1'b0, r_s5_hl[k]})) <<< HW)
                          + (desu_pkg::PROD_W'(r_s5_lh[k]) <<< HW)
                          + (desu_pkg::PROD_W'(r_s5_hh[k]) <<< (2*HW));
        end
    end

    // stage 7: row sum and rounding offset
    logic                                r_v7;
    logic signed [desu_pkg::ACC_W-1:0]   r_s7_acc [NC];
    logic signed [desu_pkg::ACC_W-1:0]   n_acc [NC];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            n_acc[i] = desu_pkg::ACC_W'(r_s6_prod[i])
                     + (desu_pkg::ACC_W'(1) <<< (desu_pkg::RSHIFT - 1));
        end
        for (int i = 0; i < NN; i++) begin
            n_acc[i] = n_acc[i] + desu_pkg::ACC_W'(r_s6_prod[NC+i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NC; i++) begin
            r_s7_acc[i] <= n_acc[i];
        end
    end

    // stage 8: scale down, clip, mask unused components
    logic                                  r_strobe;
    logic signed [desu_pkg::STRESS_W-1:0]  r_stress [NC];
    logic                                  r_sat;
    logic signed [desu_pkg::STRESS_W-1:0]  n_stress [NC];
    logic                                  n_sat;
    logic [2:0]                            ncomp;
    localparam int TOP = desu_pkg::RSHIFT + desu_pkg::STRESS_W - 1;

    always_comb begin
        unique case (r_dimension)
            desu_pkg::DIM_1D: ncomp = 3'd1;
            desu_pkg::DIM_2D: ncomp = 3'd3;
            desu_pkg::DIM_3D: ncomp = 3'd6;
            default:          ncomp = 3'd0;
        endcase
        n_sat = 1'b0;
        for (int i = 0; i < NC; i++) begin
            n_stress[i] = '0;
            if (i < int'(ncomp)) begin
                if ((&r_s7_acc[i][desu_pkg::ACC_W-1:TOP])
                    || !(|r_s7_acc[i][desu_pkg::ACC_W-1:TOP])) begin
                    n_stress[i] = $signed(r_s7_acc[i][TOP:desu_pkg::RSHIFT]);
                end else begin
                    n_sat       = 1'b1;
                    n_stress[i] = r_s7_acc[i][desu_pkg::ACC_W-1]
                                ? {1'b1, {(desu_pkg::STRESS_W-1){1'b0}}}
                                : {1'b0, {(desu_pkg::STRESS_W-1){1'b1}}};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat <= n_sat;
        for (int i = 0; i < NC; i++) begin
            r_stress[i] <= n_stress[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_v6     <= 1'b0;
            r_v7     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= accept;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_v5     <= r_v4;
            r_v6     <= r_v5;
            r_v7     <= r_v6;
            r_strobe <= r_v7;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_stress_0  = r_stress[0];
    assign o_stress_1  = r_stress[1];
    assign o_stress_2  = r_stress[2];
    assign o_stress_3  = r_stress[3];
    assign o_stress_4  = r_stress[4];
    assign o_stress_5  = r_stress[5];
    assign o_saturated = r_sat;

endmodule
